// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/bb3_pkg.sv
package bb3_pkg;

    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_MAX_CHANNELS   = 3;
    localparam int DEF_KERNEL_DIVISOR = 9;

    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 13;
    localparam int CH_W       = 2;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam logic [1:0] CHANNELS_RESET = 2'd1;
    localparam logic [1:0] THREE_CHANNELS = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_cfg_reg;

    // Window indexed [row][column]; row 0 is the oldest line, column 2 the newest.
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic x_zero;   // result centers on the last pixel of an earlier row
        logic wide;     // image is at least two pixels wide
        logic x_one;    // result centers on column 0, so the left column repeats
        logic top_rep;  // center row is the first row
        logic bot_rep;  // center row is the last row
    } t_kernel_ctl;

endpackage

// File: rtl/bb3_kernel.sv
module bb3_kernel #(
    parameter int KERNEL_DIVISOR = bb3_pkg::DEF_KERNEL_DIVISOR
) (
    input  bb3_pkg::t_window           i_old,
    input  bb3_pkg::t_window           i_new,
    input  bb3_pkg::t_kernel_ctl       i_ctl,
    output logic [bb3_pkg::PIX_W-1:0]  o_value
);

    localparam int COL_SUM_W = bb3_pkg::PIX_W + 2;
    localparam int SUM_W     = bb3_pkg::PIX_W + 4;
    localparam int SHIFT     = 16;
    localparam int RECIP     = ((1 << SHIFT) + KERNEL_DIVISOR - 1) / KERNEL_DIVISOR;
    localparam int PROD_W    = SUM_W + SHIFT + 1;
    localparam int PIX_MAX   = (1 << bb3_pkg::PIX_W) - 1;

    logic [COL_SUM_W-1:0] edge_left_sum;
    logic [COL_SUM_W-1:0] edge_right_sum;
    logic [COL_SUM_W-1:0] left_sum;
    logic [COL_SUM_W-1:0] mid_sum;
    logic [COL_SUM_W-1:0] right_sum;
    logic [SUM_W-1:0]     total;
    logic [PROD_W-1:0]    product;
    logic [SUM_W-1:0]     quotient;

    function automatic logic [COL_SUM_W-1:0] col_sum(
        input bb3_pkg::t_window win,
        input logic [1:0]       col,
        input logic             top_rep,
        input logic             bot_rep
    );
        logic [bb3_pkg::PIX_W-1:0] top;
        logic [bb3_pkg::PIX_W-1:0] mid;
        logic [bb3_pkg::PIX_W-1:0] bot;
        mid = win[1][col];
        top = top_rep ? mid : win[0][col];
        bot = bot_rep ? mid : win[2][col];
        return COL_SUM_W'(top) + COL_SUM_W'(mid) + COL_SUM_W'(bot);
    endfunction

    // At column 0 the center pixel closed the previous row and the window has
    // not shifted yet, so the right column stands in for the missing neighbor.
    assign edge_left_sum  = col_sum(i_old, i_ctl.wide ? 2'd1 : 2'd2, i_ctl.top_rep,
                                    i_ctl.bot_rep);
    assign edge_right_sum = col_sum(i_old, 2'd2, i_ctl.top_rep, i_ctl.bot_rep);
    assign left_sum       = col_sum(i_new, i_ctl.x_one ? 2'd1 : 2'd0, i_ctl.top_rep,
                                    i_ctl.bot_rep);
    assign mid_sum        = col_sum(i_new, 2'd1, i_ctl.top_rep, i_ctl.bot_rep);
    assign right_sum      = col_sum(i_new, 2'd2, i_ctl.top_rep, i_ctl.bot_rep);

    always_comb begin
        if (i_ctl.x_zero) begin
            total = SUM_W'(edge_left_sum) + (SUM_W'(edge_right_sum) << 1);
        end else begin
            total = SUM_W'(left_sum) + SUM_W'(mid_sum) + SUM_W'(right_sum);
        end
    end

    // Truncating division by the kernel divisor through a rounded-up reciprocal;
    // exact for every sum below 2^12.
    assign product  = PROD_W'(total) * PROD_W'(RECIP);
    assign quotient = product[SHIFT +: SUM_W];
    assign o_value  = (quotient > SUM_W'(PIX_MAX)) ? bb3_pkg::PIX_W'(PIX_MAX)
                                                  : quotient[bb3_pkg::PIX_W-1:0];

endmodule

// File: rtl/box_blur_3x3_stream.sv
// 3x3 box blur on a raster-order stream of 8-bit samples with one or three
// interleaved channels. The block takes one sample per clock unless the output
// stalls and, once a frame is under way, gives one result per sample: the
// result for a pixel leaves with the sample of the pixel one row plus one
// pixel later, so after the last sample of a frame the source sends one row
// plus one pixel of flush transfers (tuser high) to drain it; flushes sent
// earlier are taken and dropped. An item is registered in the input stage,
// where the line store is read, then in the output register; one line-store
// read and one write per cycle set the rate of one item per clock unless the
// output stalls. Edges replicate the nearest pixel. The line store needs no
// clearing after reset. The user must write registers only while the stream
// is idle, which the block does not enforce; a register write restarts the frame.
`include "assert_macros.svh"

module box_blur_3x3_stream #(
    parameter int MAX_WIDTH      = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS   = bb3_pkg::DEF_MAX_CHANNELS,
    parameter int KERNEL_DIVISOR = bb3_pkg::DEF_KERNEL_DIVISOR
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [bb3_pkg::PIX_W-1:0]       i_s_tdata,   // sample
    input  logic                            i_s_tuser,   // mode
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [bb3_pkg::PIX_W-1:0]       o_m_tdata,   // out_value
    output logic                            o_m_tlast
);

    localparam int PIX_W      = bb3_pkg::PIX_W;
    localparam int ROW_W      = bb3_pkg::ROW_W;
    localparam int CH_W       = bb3_pkg::CH_W;
    localparam int CFG_DATA_W = bb3_pkg::CFG_DATA_W;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int PAIR_W     = 2 * PIX_W;
    localparam int WIDTH_INIT = (bb3_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                   : bb3_pkg::WIDTH_RESET;

    typedef struct packed {
        logic [PIX_W-1:0]     sample;
        logic [ADDR_W-1:0]    addr;
        logic [CH_W-1:0]      ch;
        logic                 emit;
        logic                 last;
        bb3_pkg::t_kernel_ctl ctl;
    } t_s1;

    // Configuration, held in the form the datapath uses.
    logic [WID_W-1:0]      r_width;
    logic [CFG_DATA_W-1:0] r_height;
    logic                  r_three;
    logic [WID_W-1:0]      cfg_width;
    logic                  cfg_hit;

    // Position of the next item.
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CH_W-1:0]  r_ch, n_ch;

    logic             r_s1_valid;
    t_s1              r_s1, n_s1;
    logic             r_fwd;
    logic [PAIR_W-1:0] r_fwd_data;
    logic [PAIR_W-1:0] r_rd_data;
    logic [PAIR_W-1:0] r_mem [MEM_DEPTH];

    bb3_pkg::t_window r_win [MAX_CHANNELS];
    bb3_pkg::t_window win_old;
    bb3_pkg::t_window win_new;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_value;
    logic             r_out_last;

    logic              s_take;
    logic              draining;
    logic              take;
    logic              s1_fire;
    logic [CH_W-1:0]   ch_last;
    logic              col_last;
    logic [ROW_W-1:0]  h_plus1;
    logic              x_zero;
    logic              in_emit;
    logic              in_last;
    logic [ADDR_W-1:0] addr_now;
    logic [PAIR_W-1:0] rd_pair;
    logic [PAIR_W-1:0] wr_pair;
    logic [PIX_W-1:0]  kernel_value;

    // ---------------------------------------------------------------- config
    assign cfg_hit = i_cfg_wr_en &&
                     (i_cfg_index == bb3_pkg::REG_IMAGE_WIDTH ||
                      i_cfg_index == bb3_pkg::REG_IMAGE_HEIGHT ||
                      i_cfg_index == bb3_pkg::REG_CHANNEL_COUNT);

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_width = WID_W'(1);
        end else if (32'(i_cfg_wdata) > MAX_WIDTH) begin
            cfg_width = WID_W'(MAX_WIDTH);
        end else begin
            cfg_width = WID_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(WIDTH_INIT);
            r_height <= CFG_DATA_W'(bb3_pkg::HEIGHT_RESET);
            r_three  <= (bb3_pkg::CHANNELS_RESET == bb3_pkg::THREE_CHANNELS) &&
                        (MAX_CHANNELS >= 3);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bb3_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= cfg_width;
                end
                bb3_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= (i_cfg_wdata == '0) ? CFG_DATA_W'(1) : i_cfg_wdata;
                end
                bb3_pkg::REG_CHANNEL_COUNT: begin
                    r_three <= (i_cfg_wdata[1:0] == bb3_pkg::THREE_CHANNELS) &&
                               (MAX_CHANNELS >= 3);
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------- input stage
    assign s_take   = i_s_tvalid && o_s_tready;
    assign draining = r_row >= ROW_W'(r_height);
    // A flush before the frame's last sample is dropped without touching state.
    assign take     = s_take && (draining || !i_s_tuser);

    assign ch_last  = r_three ? CH_W'(2) : '0;
    assign col_last = (WID_W'(r_col) == r_width - WID_W'(1));
    assign h_plus1  = ROW_W'(r_height) + ROW_W'(1);
    assign x_zero   = (r_col == '0);
    assign in_emit  = (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && !x_zero);
    assign in_last  = in_emit && (r_ch == ch_last) && (r_row == h_plus1) && x_zero;
    assign addr_now = ADDR_W'(r_col) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(r_ch);

    always_comb begin
        n_s1.sample      = draining ? '0 : i_s_tdata;
        n_s1.addr        = addr_now;
        n_s1.ch          = r_ch;
        n_s1.emit        = in_emit;
        n_s1.last        = in_last;
        n_s1.ctl.x_zero  = x_zero;
        n_s1.ctl.wide    = (r_width >= WID_W'(2));
        n_s1.ctl.x_one   = (r_col == COL_W'(1));
        n_s1.ctl.top_rep = x_zero ? (r_row == ROW_W'(2)) : (r_row == ROW_W'(1));
        n_s1.ctl.bot_rep = x_zero ? (r_row == h_plus1) : (r_row == ROW_W'(r_height));
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ch  = r_ch;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
            n_ch  = '0;
        end else if (take) begin
            if (in_last) begin
                n_col = '0;
                n_row = '0;
                n_ch  = '0;
            end else if (r_ch == ch_last) begin
                n_ch = '0;
                if (col_last) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end else begin
                n_ch = r_ch + CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ch  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ch  <= n_ch;
        end
    end

    assign s1_fire    = r_s1_valid && (!r_s1.emit || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------ line store
    // Each entry holds one column of one channel for the two previous rows:
    // the older row in the low byte, the newer one in the high byte.
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_mem[r_s1.addr] <= wr_pair;
        end
        if (take) begin
            r_rd_data <= r_mem[addr_now];
        end
    end

    // A read issued in the same cycle as a write to the same entry returns the
    // old data, so the written value is kept and used instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (take) begin
            r_fwd <= s1_fire && (r_s1.addr == addr_now);
        end else if (s1_fire) begin
            r_fwd <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_fwd_data <= wr_pair;
        end
    end

    assign rd_pair = r_fwd ? r_fwd_data : r_rd_data;
    assign wr_pair = {r_s1.sample, rd_pair[PAIR_W-1:PIX_W]};

    // --------------------------------------------------------------- window
    always_comb begin
        win_old = '0;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (r_s1.ch == CH_W'(k)) begin
                win_old = r_win[k];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_new[r][0] = win_old[r][1];
            win_new[r][1] = win_old[r][2];
        end
        win_new[0][2] = rd_pair[PIX_W-1:0];
        win_new[1][2] = rd_pair[PAIR_W-1:PIX_W];
        win_new[2][2] = r_s1.sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_fire) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                if (r_s1.ch == CH_W'(k)) begin
                    r_win[k] <= win_new;
                end
            end
        end
    end

    bb3_kernel #(
        .KERNEL_DIVISOR (KERNEL_DIVISOR)
    ) u_kernel (
        .i_old   (win_old),
        .i_new   (win_new),
        .i_ctl   (r_s1.ctl),
        .o_value (kernel_value)
    );

    // -------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.emit) begin
            r_out_value <= kernel_value;
            r_out_last  <= r_s1.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tlast  = r_out_last;

    // ----------------------------------------------------------- assertions
    `CHK_IMPLY(a_fwd_needs_stage, i_clk, i_rst_n, r_fwd, r_s1_valid)
    `CHK_IMPLY(a_position_in_range, i_clk, i_rst_n, 1'b1, (WID_W'(r_col) < r_width) && !(r_ch > ch_last))
    `CHK_IMPLY(a_stall_only_when_full, i_clk, i_rst_n, !o_s_tready, r_s1_valid && r_s1.emit && r_out_valid)
    `CHK_NEXT(a_frame_restart, i_clk, i_rst_n, take && in_last, {r_row, r_col, r_ch} == '0)

endmodule
